### design/text_terminal_cursor_controller_macros.svh
// Assertion macros used by the cursor controller's top level.
`ifndef TEXT_TERMINAL_CURSOR_CONTROLLER_MACROS_SVH
`define TEXT_TERMINAL_CURSOR_CONTROLLER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TTCC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TTCC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/ttcc_pkg.sv
// Package with the constants, codes and types of the cursor controller.
package ttcc_pkg;

  localparam int COLUMNS     = 80;
  localparam int ROWS        = 30;
  localparam int GLYPH_WIDTH = 6;

  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int TAB_W      = 5;
  localparam int CHAR_W     = 8;
  localparam int GLYPH_W    = 7;
  localparam int WORD_W     = 4;
  localparam int OFF_W      = 5;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int PX_W       = COL_W + 5;
  localparam int TSUM_W     = COL_W + 1;
  localparam int STEP_W     = $clog2(COL_W);
  localparam int WORD_BITS  = 32;

  localparam logic [TAB_W-1:0] TAB_RESET = TAB_W'(4);

  localparam logic [CHAR_W-1:0] CH_BS         = CHAR_W'(8);
  localparam logic [CHAR_W-1:0] CH_TAB        = CHAR_W'(9);
  localparam logic [CHAR_W-1:0] CH_LF         = CHAR_W'(10);
  localparam logic [CHAR_W-1:0] CH_FF         = CHAR_W'(12);
  localparam logic [CHAR_W-1:0] CH_CR         = CHAR_W'(13);
  localparam logic [CHAR_W-1:0] CH_PRINT_LO   = CHAR_W'(32);
  localparam logic [CHAR_W-1:0] CH_PRINT_HI   = CHAR_W'(126);

  typedef enum logic [1:0] {
    OP_CHAR   = 2'd0,
    OP_SETPOS = 2'd1,
    OP_UP     = 2'd2,
    OP_DOWN   = 2'd3
  } opcode_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE   = 3'd0,
    ACT_DRAW   = 3'd1,
    ACT_SCR_UP = 3'd2,
    ACT_SCR_DN = 3'd3,
    ACT_CLEAR  = 3'd4
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TAB_STOP = 2'd0,
    CFG_INVERT   = 2'd1
  } cfg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC,
    ST_OUT0,
    ST_OUT1
  } state_t;

  // Status of the shared remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic in_ready;
    logic div_start;
    logic exec_load;
    logic out_valid;
    logic second;
  } ctrl_t;

endpackage

### design/ttcc_div.sv
// Shared restoring remainder unit, one dividend bit per cycle.
module ttcc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [ttcc_pkg::COL_W-1:0]  dividend,
  input  logic [ttcc_pkg::TAB_W-1:0]  divisor,
  output ttcc_pkg::div_stat_t         stat,
  output logic [ttcc_pkg::TAB_W-1:0]  rem
);
  import ttcc_pkg::*;

  logic [COL_W-1:0]  shreg;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic              done;
  logic [TAB_W:0]    trial;
  logic              fits;
  logic [TAB_W-1:0]  rem_next;

  // The partial remainder stays below the divisor, so it fits TAB_W bits.
  always_comb begin
    trial    = {rem, shreg[COL_W-1]};
    fits     = (trial >= {1'b0, divisor});
    rem_next = fits ? TAB_W'(trial - {1'b0, divisor}) : trial[TAB_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + STEP_W'(1);
        if (step == STEP_W'(COL_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      shreg <= dividend;
    end else if (busy) begin
      rem   <= rem_next;
      shreg <= {shreg[COL_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### design/ttcc_seq.sv
// Sequencer stepping one transaction via accept, TAB remainder, execute and output.
module ttcc_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_is_tab,
  input  ttcc_pkg::div_stat_t div_stat,
  input  logic                two_results,
  input  logic                out_ready,
  output ttcc_pkg::ctrl_t     ctrl
);
  import ttcc_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctrl       = '0;
    case (state)
      ST_IDLE: begin
        ctrl.in_ready = 1'b1;
        if (in_valid) begin
          if (in_is_tab) begin
            ctrl.div_start = 1'b1;
            state_next     = ST_DIV;
          end else begin
            state_next = ST_EXEC;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctrl.exec_load = 1'b1;
        state_next     = ST_OUT0;
      end
      ST_OUT0: begin
        ctrl.out_valid = 1'b1;
        if (out_ready) begin
          state_next = two_results ? ST_OUT1 : ST_IDLE;
        end
      end
      ST_OUT1: begin
        ctrl.out_valid = 1'b1;
        ctrl.second    = 1'b1;
        if (out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/text_terminal_cursor_controller.sv
// Top level of the text-terminal cursor controller.
// This block keeps the text cursor (column and row) of an 80 by 30 character
// terminal. Each input transaction is a character byte or a cursor command
// (set position, up, down); it yields one or two output transactions, the
// last one flagged with last. Printable codes 32 to 126 give a draw-glyph
// result with the font entry, the text cell and where the glyph's left pixel
// sits in the 32-bit bitmap words; a draw in the last column of the last row
// is followed by a scroll-up result. CR and LF go to column 0 and advance a
// line, TAB goes to the next tab stop, FF clears the screen and homes the
// cursor, and backspace moves left, wrapping to the row above. Every result
// reports the cursor position after the whole input. The block works on one
// input at a time: in_ready is high only while it is idle. Without output
// stalls an input goes through accept, execute and present before its first
// output transaction ends; a second result has its own present step. A TAB
// also waits in a remainder step before execute, because the column remainder
// modulo the tab width comes from a shared restoring remainder unit that
// retires one column bit per cycle. Configuration writes are always accepted
// and must be made only while the block is idle; a tab width of 0 acts as 1.
module text_terminal_cursor_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [ttcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ttcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       opcode,
  input  logic [ttcc_pkg::CHAR_W-1:0]      char_code,
  input  logic [ttcc_pkg::COL_W-1:0]       target_col,
  input  logic [ttcc_pkg::ROW_W-1:0]       target_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [ttcc_pkg::ACT_W-1:0]       action,
  output logic [ttcc_pkg::GLYPH_W-1:0]     glyph_index,
  output logic [ttcc_pkg::COL_W-1:0]       draw_col,
  output logic [ttcc_pkg::ROW_W-1:0]       draw_row,
  output logic [ttcc_pkg::WORD_W-1:0]      word_index,
  output logic [ttcc_pkg::OFF_W-1:0]       bit_offset,
  output logic                             spans_two_words,
  output logic                             fill_inverted,
  output logic [ttcc_pkg::COL_W-1:0]       cursor_col,
  output logic [ttcc_pkg::ROW_W-1:0]       cursor_row,
  output logic                             last
);
  import ttcc_pkg::*;

  // Configuration registers.
  logic [TAB_W-1:0] tab_stop_width;
  logic             invert_video;
  logic [TAB_W-1:0] tab_eff;

  // Cursor state.
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;

  // Input transaction captured at acceptance.
  opcode_t          op_q;
  logic [CHAR_W-1:0] char_q;
  logic [COL_W-1:0] tcol_q;
  logic [ROW_W-1:0] trow_q;

  // Result registers, loaded in the execute step.
  action_t            act0;
  logic [GLYPH_W-1:0] glyph0;
  logic [COL_W-1:0]   dcol0;
  logic [ROW_W-1:0]   drow0;
  logic [WORD_W-1:0]  word0;
  logic [OFF_W-1:0]   off0;
  logic               spans0;
  logic               fill0;
  logic               two;

  // Next values computed from the captured transaction.
  action_t            act0_next;
  logic [GLYPH_W-1:0] glyph0_next;
  logic [COL_W-1:0]   dcol0_next;
  logic [ROW_W-1:0]   drow0_next;
  logic [WORD_W-1:0]  word0_next;
  logic [OFF_W-1:0]   off0_next;
  logic               spans0_next;
  logic               fill0_next;
  logic               two_next;
  logic [COL_W-1:0]   cur_col_next;
  logic [ROW_W-1:0]   cur_row_next;

  logic               at_last_row;
  logic [ROW_W-1:0]   row_adv;
  logic [TSUM_W-1:0]  tab_sum;
  logic [COL_W-1:0]   col_inc;
  logic [PX_W-1:0]    px;
  logic [OFF_W+1:0]   off_end;

  ctrl_t              ctrl;
  div_stat_t          div_stat;
  logic [TAB_W-1:0]   rem;
  logic               in_is_tab;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tab_stop_width <= TAB_RESET;
      invert_video   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TAB_STOP: tab_stop_width <= cfg_data[TAB_W-1:0];
        CFG_INVERT:   invert_video   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign tab_eff = (tab_stop_width == '0) ? TAB_W'(1) : tab_stop_width;

  // A TAB needs the column remainder before it can execute.
  assign in_is_tab = (opcode_t'(opcode) == OP_CHAR) && (char_code == CH_TAB);

  ttcc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_is_tab   (in_is_tab),
    .div_stat    (div_stat),
    .two_results (two),
    .out_ready   (out_ready),
    .ctrl        (ctrl)
  );

  // The remainder unit starts in the accept cycle from the current column.
  ttcc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctrl.div_start),
    .dividend (cur_col),
    .divisor  (tab_eff),
    .stat     (div_stat),
    .rem      (rem)
  );

  always_ff @(posedge clk) begin
    if (in_valid && ctrl.in_ready) begin
      op_q   <= opcode_t'(opcode);
      char_q <= char_code;
      tcol_q <= target_col;
      trow_q <= target_row;
    end
  end

  // Execute step: decode the captured transaction against the cursor.
  always_comb begin
    at_last_row = (cur_row >= ROW_W'(ROWS - 1));
    row_adv     = at_last_row ? cur_row : cur_row + ROW_W'(1);
    // The remainder never exceeds the column, so the sum cannot underflow.
    tab_sum     = TSUM_W'(cur_col) - TSUM_W'(rem) + TSUM_W'(tab_eff);
    col_inc     = cur_col + COL_W'(1);
    px          = PX_W'(cur_col) * PX_W'(GLYPH_WIDTH);
    off_end     = (OFF_W + 2)'(px[OFF_W-1:0]) + (OFF_W + 2)'(GLYPH_WIDTH);

    act0_next    = ACT_NONE;
    glyph0_next  = '0;
    dcol0_next   = '0;
    drow0_next   = '0;
    word0_next   = '0;
    off0_next    = '0;
    spans0_next  = 1'b0;
    fill0_next   = 1'b0;
    two_next     = 1'b0;
    cur_col_next = cur_col;
    cur_row_next = cur_row;

    case (op_q)
      OP_SETPOS: begin
        // Out-of-range targets leave the cursor where it is.
        if (tcol_q <= COL_W'(COLUMNS - 1) && trow_q <= ROW_W'(ROWS - 1)) begin
          cur_col_next = tcol_q;
          cur_row_next = trow_q;
        end
      end
      OP_UP: begin
        if (cur_row != '0) begin
          cur_row_next = cur_row - ROW_W'(1);
        end else begin
          cur_col_next = '0;
          act0_next    = ACT_SCR_DN;
        end
      end
      OP_DOWN: begin
        cur_row_next = row_adv;
        if (at_last_row) begin
          act0_next = ACT_SCR_UP;
        end
      end
      OP_CHAR: begin
        if (char_q == CH_CR || char_q == CH_LF) begin
          cur_col_next = '0;
          cur_row_next = row_adv;
          if (at_last_row) begin
            act0_next = ACT_SCR_UP;
          end
        end else if (char_q == CH_TAB) begin
          if (tab_sum >= TSUM_W'(COLUMNS)) begin
            cur_col_next = '0;
            cur_row_next = row_adv;
            if (at_last_row) begin
              act0_next = ACT_SCR_UP;
            end
          end else begin
            cur_col_next = tab_sum[COL_W-1:0];
          end
        end else if (char_q == CH_FF) begin
          cur_col_next = '0;
          cur_row_next = '0;
          act0_next    = ACT_CLEAR;
          fill0_next   = invert_video;
        end else if (char_q == CH_BS) begin
          if (cur_col != '0) begin
            cur_col_next = cur_col - COL_W'(1);
          end else if (cur_row != '0) begin
            cur_col_next = COL_W'(COLUMNS - 1);
            cur_row_next = cur_row - ROW_W'(1);
          end else begin
            // Backspace at the home cell scrolls down and stays home.
            act0_next = ACT_SCR_DN;
          end
        end else if (char_q >= CH_PRINT_LO && char_q <= CH_PRINT_HI) begin
          act0_next   = ACT_DRAW;
          fill0_next  = invert_video;
          glyph0_next = GLYPH_W'(char_q - CH_PRINT_LO);
          dcol0_next  = cur_col;
          drow0_next  = cur_row;
          word0_next  = px[OFF_W +: WORD_W];
          off0_next   = px[OFF_W-1:0];
          spans0_next = (off_end > (OFF_W + 2)'(WORD_BITS));
          if (col_inc >= COL_W'(COLUMNS)) begin
            cur_col_next = '0;
            cur_row_next = row_adv;
            two_next     = at_last_row;
          end else begin
            cur_col_next = col_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      two     <= 1'b0;
    end else if (ctrl.exec_load) begin
      cur_col <= cur_col_next;
      cur_row <= cur_row_next;
      two     <= two_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.exec_load) begin
      act0   <= act0_next;
      glyph0 <= glyph0_next;
      dcol0  <= dcol0_next;
      drow0  <= drow0_next;
      word0  <= word0_next;
      off0   <= off0_next;
      spans0 <= spans0_next;
      fill0  <= fill0_next;
    end
  end

  // The second result is always the scroll-up that follows a wrapping draw.
  assign in_ready        = ctrl.in_ready;
  assign out_valid       = ctrl.out_valid;
  assign action          = ctrl.second ? ACT_SCR_UP : act0;
  assign glyph_index     = ctrl.second ? '0 : glyph0;
  assign draw_col        = ctrl.second ? '0 : dcol0;
  assign draw_row        = ctrl.second ? '0 : drow0;
  assign word_index      = ctrl.second ? '0 : word0;
  assign bit_offset      = ctrl.second ? '0 : off0;
  assign spans_two_words = ctrl.second ? 1'b0 : spans0;
  assign fill_inverted   = ctrl.second ? 1'b0 : fill0;
  assign cursor_col      = cur_col;
  assign cursor_row      = cur_row;
  assign last            = ctrl.second | ~two;

`include "text_terminal_cursor_controller_macros.svh"

  `TTCC_ASSERT_SAME(a_cursor_range, 1'b1,
    (cur_col <= COL_W'(COLUMNS - 1)) && (cur_row <= ROW_W'(ROWS - 1)),
    "cursor left the screen")
  `TTCC_ASSERT_SAME(a_no_overlap, in_ready, !out_valid && !div_stat.busy,
    "input accepted while a transaction is still in progress")
  `TTCC_ASSERT_NEXT(a_last_frees, out_valid && out_ready && last, in_ready,
    "block not idle after the final result")
  `TTCC_ASSERT_NEXT(a_cursor_hold, out_valid && !out_ready,
    $stable(cur_col) && $stable(cur_row) && $stable(two),
    "cursor changed while a result was stalled")

endmodule

### tb/sv/tb_text_terminal_cursor_controller.sv
`timescale 1ns / 1ps
// Self-checking testbench for the text-terminal cursor controller.
module tb_text_terminal_cursor_controller;
  import ttcc_pkg::*;

  // The run stops here no matter what.
  localparam int CYCLE_LIMIT = 500_000;
  // Cycles of quiet after the last result before a register write or the
  // end of the run. A TAB keeps the block busy the longest, so this covers
  // every input with margin.
  localparam int SETTLE_CYCLES = 20;
  localparam int NUM_DIRECTED = 27;
  localparam int NUM_PHASES = 8;

  // Idling styles for the input and output sides.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  // One screen command as the block reports it, in port order.
  typedef struct packed {
    action_t              act;
    logic [GLYPH_W-1:0]   glyph;
    logic [COL_W-1:0]     dcol;
    logic [ROW_W-1:0]     drow;
    logic [WORD_W-1:0]    word;
    logic [OFF_W-1:0]     off;
    logic                 span;
    logic                 fill;
    logic [COL_W-1:0]     ccol;
    logic [ROW_W-1:0]     crow;
    logic                 last;
  } screen_cmd_t;

  // One row of the directed stimulus. Where typed is set, the row also
  // carries the one result it must give: a non-draw command and a cursor.
  typedef struct {
    opcode_t              op;
    logic [CHAR_W-1:0]    ch;
    logic [COL_W-1:0]     tcol;
    logic [ROW_W-1:0]     trow;
    bit                   typed;
    action_t              want_act;
    logic [COL_W-1:0]     want_col;
    logic [ROW_W-1:0]     want_row;
  } stim_row_t;

  // One register setting with the idling style and item count used under it.
  typedef struct {
    logic [TAB_W-1:0]     tab;
    bit                   inv;
    idle_mode_t           mode;
    int                   items;
  } phase_t;

  // The directed part starts right after reset: tab width 4, normal video,
  // cursor at the home position. The comments give the cursor before the row.
  stim_row_t directed_rows [NUM_DIRECTED] = '{
    // Cursor up and backspace at the home position scroll down.
    '{OP_UP,     8'd0,             7'd0,   5'd0,  1'b1, ACT_SCR_DN, 7'd0,  5'd0},
    '{OP_CHAR,   CH_BS,            7'd0,   5'd0,  1'b1, ACT_SCR_DN, 7'd0,  5'd0},
    '{OP_CHAR,   8'h41,            7'd0,   5'd0,  1'b0, ACT_NONE,   7'd0,  5'd0},
    '{OP_CHAR,   CH_TAB,           7'd0,   5'd0,  1'b0, ACT_NONE,   7'd0,  5'd0},
    // Draw in the bottom-right cell: a draw followed by a scroll-up.
    '{OP_SETPOS, 8'd0,             7'd79,  5'd29, 1'b1, ACT_NONE,   7'd79, 5'd29},
    '{OP_CHAR,   CH_PRINT_HI,      7'd0,   5'd0,  1'b0, ACT_NONE,   7'd0,  5'd0},
    // Set position out of range on either axis is ignored.
    '{OP_SETPOS, 8'd0,             7'd80,  5'd0,  1'b1, ACT_NONE,   7'd0,  5'd29},
    '{OP_SETPOS, 8'd0,             7'd0,   5'd30, 1'b1, ACT_NONE,   7'd0,  5'd29},
    '{OP_SETPOS, 8'hff,            7'd127, 5'd31, 1'b1, ACT_NONE,   7'd0,  5'd29},
    // Line feed and cursor down on the last row scroll up.
    '{OP_CHAR,   CH_LF,            7'd0,   5'd0,  1'b1, ACT_SCR_UP, 7'd0,  5'd29},
    '{OP_DOWN,   8'd0,             7'd0,   5'd0,  1'b1, ACT_SCR_UP, 7'd0,  5'd29},
    // Backspace from column 0 wraps to the end of the row above.
    '{OP_CHAR,   CH_BS,            7'd0,   5'd0,  1'b1, ACT_NONE,   7'd79, 5'd28},
    '{OP_CHAR,   CH_CR,            7'd0,   5'd0,  1'b1, ACT_NONE,   7'd0,  5'd29},
    '{OP_CHAR,   CH_PRINT_LO,      7'd0,   5'd0,  1'b0, ACT_NONE,   7'd0,  5'd0},
    // Codes just outside the printable range and the byte extremes do nothing.
    '{OP_CHAR,   CH_PRINT_LO - 8'd1, 7'd0, 5'd0,  1'b1, ACT_NONE,   7'd1,  5'd29},
    '{OP_CHAR,   CH_PRINT_HI + 8'd1, 7'd0, 5'd0,  1'b1, ACT_NONE,   7'd1,  5'd29},
    '{OP_CHAR,   8'hff,            7'd127, 5'd31, 1'b1, ACT_NONE,   7'd1,  5'd29},
    '{OP_CHAR,   8'h00,            7'd0,   5'd0,  1'b1, ACT_NONE,   7'd1,  5'd29},
    // Form feed clears and homes.
    '{OP_CHAR,   CH_FF,            7'd0,   5'd0,  1'b1, ACT_CLEAR,  7'd0,  5'd0},
    '{OP_DOWN,   8'd0,             7'd0,   5'd0,  1'b1, ACT_NONE,   7'd0,  5'd1},
    // A tab past the last column wraps to the next line.
    '{OP_SETPOS, 8'd0,             7'd76,  5'd5,  1'b1, ACT_NONE,   7'd76, 5'd5},
    '{OP_CHAR,   CH_TAB,           7'd0,   5'd0,  1'b0, ACT_NONE,   7'd0,  5'd0},
    // Column 5 puts the glyph at pixel 30, across two bitmap words.
    '{OP_SETPOS, 8'd0,             7'd5,   5'd7,  1'b1, ACT_NONE,   7'd5,  5'd7},
    '{OP_CHAR,   8'h5a,            7'd0,   5'd0,  1'b0, ACT_NONE,   7'd0,  5'd0},
    // A draw in the last column above the bottom row wraps without a scroll.
    '{OP_SETPOS, 8'd0,             7'd79,  5'd0,  1'b1, ACT_NONE,   7'd79, 5'd0},
    '{OP_CHAR,   8'h78,            7'd0,   5'd0,  1'b0, ACT_NONE,   7'd0,  5'd0},
    '{OP_UP,     8'd0,             7'd0,   5'd0,  1'b1, ACT_NONE,   7'd0,  5'd0}
  };

  // Register settings for the random part. Tab widths 0 and 31 lie outside
  // the documented range but the port allows them, so they are run too.
  phase_t phases [NUM_PHASES] = '{
    '{5'd4,  1'b0, IDLE_NONE, 190},
    '{5'd1,  1'b1, IDLE_SEND, 190},
    '{5'd16, 1'b0, IDLE_RECV, 190},
    '{5'd0,  1'b1, IDLE_BOTH, 190},
    '{5'd31, 1'b0, IDLE_NONE, 190},
    '{5'd7,  1'b1, IDLE_SEND, 190},
    '{5'd3,  1'b0, IDLE_RECV, 190},
    '{5'd16, 1'b1, IDLE_BOTH, 190}
  };

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [1:0]            opcode = '0;
  logic [CHAR_W-1:0]     char_code = '0;
  logic [COL_W-1:0]      target_col = '0;
  logic [ROW_W-1:0]      target_row = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ACT_W-1:0]      action;
  logic [GLYPH_W-1:0]    glyph_index;
  logic [COL_W-1:0]      draw_col;
  logic [ROW_W-1:0]      draw_row;
  logic [WORD_W-1:0]     word_index;
  logic [OFF_W-1:0]      bit_offset;
  logic                  spans_two_words;
  logic                  fill_inverted;
  logic [COL_W-1:0]      cursor_col;
  logic [ROW_W-1:0]      cursor_row;
  logic                  last;

  // Predicted cursor, moved per accepted input; register copies, set per write.
  logic [COL_W-1:0]      model_col;
  logic [ROW_W-1:0]      model_row;
  logic [TAB_W-1:0]      tab_width_reg;
  logic                  invert_reg;

  // Screen commands predicted but not yet seen at the output, oldest first.
  screen_cmd_t           pending_cmds [$];

  idle_mode_t            idle_mode = IDLE_NONE;
  int                    cycle_count = 0;
  int                    mismatch_count = 0;
  int                    inputs_sent = 0;
  int                    cmds_checked = 0;
  int                    draws_seen = 0;
  int                    scrolls_seen = 0;
  int                    clears_seen = 0;

  text_terminal_cursor_controller i_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .char_code       (char_code),
    .target_col      (target_col),
    .target_row      (target_row),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .action          (action),
    .glyph_index     (glyph_index),
    .draw_col        (draw_col),
    .draw_row        (draw_row),
    .word_index      (word_index),
    .bit_offset      (bit_offset),
    .spans_two_words (spans_two_words),
    .fill_inverted   (fill_inverted),
    .cursor_col      (cursor_col),
    .cursor_row      (cursor_row),
    .last            (last)
  );

  always #1 clk = ~clk;

  // Moves the predicted cursor down a row; returns 1 when it sits on the
  // last row and the screen must scroll up instead.
  function automatic bit next_line();
    if (model_row >= ROWS - 1) return 1'b1;
    model_row = model_row + 1'b1;
    return 1'b0;
  endfunction

  // Works out the screen commands for one input and moves the predicted
  // cursor. Sets skipped when the input changes nothing at all.
  task automatic terminal_step(input opcode_t op, input logic [CHAR_W-1:0] ch,
                               input logic [COL_W-1:0] tcol,
                               input logic [ROW_W-1:0] trow,
                               output screen_cmd_t cmds [2], output int count,
                               output bit skipped);
    int tw;
    int next_col;
    int px;
    cmds[0] = '0;
    cmds[1] = '0;
    cmds[0].act = ACT_NONE;
    cmds[1].act = ACT_SCR_UP;
    count = 1;
    skipped = 1'b0;
    case (op)
      OP_SETPOS: begin
        if (tcol <= COLUMNS - 1 && trow <= ROWS - 1) begin
          model_col = tcol;
          model_row = trow;
        end else begin
          skipped = 1'b1;
        end
      end
      OP_UP: begin
        if (model_row != 0) begin
          model_row = model_row - 1'b1;
        end else begin
          model_col = '0;
          cmds[0].act = ACT_SCR_DN;
        end
      end
      OP_DOWN: begin
        if (next_line()) cmds[0].act = ACT_SCR_UP;
      end
      default: begin
        if (ch == CH_CR || ch == CH_LF) begin
          model_col = '0;
          if (next_line()) cmds[0].act = ACT_SCR_UP;
        end else if (ch == CH_TAB) begin
          tw = (tab_width_reg == 0) ? 1 : int'(tab_width_reg);
          next_col = (int'(model_col) / tw + 1) * tw;
          if (next_col >= COLUMNS) begin
            model_col = '0;
            if (next_line()) cmds[0].act = ACT_SCR_UP;
          end else begin
            model_col = COL_W'(next_col);
          end
        end else if (ch == CH_FF) begin
          model_col = '0;
          model_row = '0;
          cmds[0].act = ACT_CLEAR;
          cmds[0].fill = invert_reg;
        end else if (ch == CH_BS) begin
          if (model_col != 0) begin
            model_col = model_col - 1'b1;
          end else if (model_row != 0) begin
            model_col = COL_W'(COLUMNS - 1);
            model_row = model_row - 1'b1;
          end else begin
            cmds[0].act = ACT_SCR_DN;
          end
        end else if (ch >= CH_PRINT_LO && ch <= CH_PRINT_HI) begin
          // The glyph's left pixel decides the bitmap word and the offset in it.
          px = int'(model_col) * GLYPH_WIDTH;
          cmds[0].act = ACT_DRAW;
          cmds[0].fill = invert_reg;
          cmds[0].glyph = GLYPH_W'(ch - CH_PRINT_LO);
          cmds[0].dcol = model_col;
          cmds[0].drow = model_row;
          cmds[0].word = WORD_W'(px / WORD_BITS);
          cmds[0].off = OFF_W'(px % WORD_BITS);
          cmds[0].span = (px % WORD_BITS) + GLYPH_WIDTH > WORD_BITS;
          model_col = model_col + 1'b1;
          if (model_col >= COLUMNS) begin
            model_col = '0;
            if (next_line()) count = 2;
          end
        end else begin
          skipped = 1'b1;
        end
      end
    endcase
    // Every result carries the cursor after the whole input.
    cmds[0].ccol = model_col;
    cmds[0].crow = model_row;
    cmds[1].ccol = model_col;
    cmds[1].crow = model_row;
    cmds[0].last = (count == 1);
    cmds[1].last = 1'b1;
  endtask

  // Decides whether the sender sits out the coming cycle.
  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SEND: return $urandom_range(99) < 67;
      IDLE_BOTH: return $urandom_range(99) < 19;
      default:   return 1'b0;
    endcase
  endfunction

  // Offers one input transaction and, once it is taken, queues what it must
  // produce. Called at a falling edge; valid is left high after the
  // handshake so that a back-to-back transaction does not drop it.
  task automatic send_input(input stim_row_t row, output bit skipped);
    screen_cmd_t cmds [2];
    screen_cmd_t typed_cmd;
    int count;
    while (sender_waits()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode <= row.op;
    char_code <= row.ch;
    target_col <= row.tcol;
    target_row <= row.trow;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    terminal_step(row.op, row.ch, row.tcol, row.trow, cmds, count, skipped);
    if (row.typed) begin
      typed_cmd = '0;
      typed_cmd.act = row.want_act;
      typed_cmd.fill = (row.want_act == ACT_CLEAR) ? invert_reg : 1'b0;
      typed_cmd.ccol = row.want_col;
      typed_cmd.crow = row.want_row;
      typed_cmd.last = 1'b1;
      pending_cmds.push_back(typed_cmd);
    end else begin
      for (int k = 0; k < count; k++) pending_cmds.push_back(cmds[k]);
    end
    inputs_sent++;
    @(negedge clk);
  endtask

  // Drops valid, waits for every queued result, then lets extra cycles pass.
  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_cmds.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  // Writes both registers in back-to-back transactions while the block is
  // idle. The unused upper bits of the invert write carry random data.
  task automatic write_registers(input logic [TAB_W-1:0] tab, input bit inv);
    wait_idle(SETTLE_CYCLES);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TAB_STOP;
    cfg_data <= tab;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tab_width_reg = tab;
    @(negedge clk);
    cfg_index <= CFG_INVERT;
    cfg_data <= {4'($urandom_range(15)), inv};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    invert_reg = inv;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Draws one random input. Most are well-formed text: printable runs,
  // control characters and in-range moves, often near the right and bottom
  // edges so that wraps and scrolls come up. The rest is noise: any byte,
  // and set-position targets over the whole field range.
  task automatic pick_random_input(output stim_row_t row);
    logic [CHAR_W-1:0] controls [5];
    int roll;
    controls = '{CH_BS, CH_TAB, CH_LF, CH_FF, CH_CR};
    roll = $urandom_range(99);
    row.typed = 1'b0;
    row.want_act = ACT_NONE;
    row.want_col = '0;
    row.want_row = '0;
    row.op = OP_CHAR;
    // Fields that the opcode does not use still carry random values.
    row.ch = CHAR_W'($urandom_range(255));
    row.tcol = COL_W'($urandom_range(127));
    row.trow = ROW_W'($urandom_range(31));
    if (roll < 45) begin
      row.ch = CHAR_W'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
    end else if (roll < 58) begin
      row.ch = controls[$urandom_range(4)];
    end else if (roll < 66) begin
      row.op = OP_SETPOS;
      if ($urandom_range(1)) begin
        row.tcol = COL_W'($urandom_range(COLUMNS - 1, COLUMNS - 8));
        row.trow = ROW_W'($urandom_range(ROWS - 1, ROWS - 4));
      end else begin
        row.tcol = COL_W'($urandom_range(COLUMNS - 1));
        row.trow = ROW_W'($urandom_range(ROWS - 1));
      end
    end else if (roll < 70) begin
      row.op = OP_SETPOS;
    end else if (roll < 79) begin
      row.op = OP_UP;
    end else if (roll < 88) begin
      row.op = OP_DOWN;
    end
  endtask

  // The receiver stalls at random in the modes that call for it.
  always @(negedge clk) begin
    case (idle_mode)
      IDLE_RECV: out_ready <= ($urandom_range(99) >= 67);
      IDLE_BOTH: out_ready <= ($urandom_range(99) >= 19);
      default:   out_ready <= 1'b1;
    endcase
  end

  // Checks every output transaction against the oldest queued prediction.
  always @(posedge clk) begin : check_output
    screen_cmd_t got;
    screen_cmd_t want;
    if (!rst && out_valid && out_ready) begin
      got.act = action_t'(action);
      got.glyph = glyph_index;
      got.dcol = draw_col;
      got.drow = draw_row;
      got.word = word_index;
      got.off = bit_offset;
      got.span = spans_two_words;
      got.fill = fill_inverted;
      got.ccol = cursor_col;
      got.crow = cursor_row;
      got.last = last;
      cmds_checked++;
      if (got.act == ACT_DRAW) draws_seen++;
      if (got.act == ACT_SCR_UP || got.act == ACT_SCR_DN) scrolls_seen++;
      if (got.act == ACT_CLEAR) clears_seen++;
      if (pending_cmds.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: result with nothing expected: act=%0d cursor=(%0d,%0d)",
                   $realtime, got.act, got.ccol, got.crow, " last=%0b", got.last);
        mismatch_count++;
      end else begin
        want = pending_cmds.pop_front();
        if (got !== want) begin
          if (mismatch_count < 10) begin
            $display("%0t: mismatch on result %0d", $realtime, cmds_checked);
            $display("  expected act=%0d glyph=%0d cell=(%0d,%0d) word=%0d off=%0d",
                     want.act, want.glyph, want.dcol, want.drow, want.word, want.off,
                     " span=%0b fill=%0b cursor=(%0d,%0d) last=%0b",
                     want.span, want.fill, want.ccol, want.crow, want.last);
            $display("  actual   act=%0d glyph=%0d cell=(%0d,%0d) word=%0d off=%0d",
                     got.act, got.glyph, got.dcol, got.drow, got.word, got.off,
                     " span=%0b fill=%0b cursor=(%0d,%0d) last=%0b",
                     got.span, got.fill, got.ccol, got.crow, got.last);
          end
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still expected",
               cycle_count, pending_cmds.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Main sequence: reset, directed rows, then one random phase per setting.
  initial begin : run_sequence
    stim_row_t row;
    bit skipped;
    int useful;
    int tries;
    model_col = '0;
    model_row = '0;
    tab_width_reg = TAB_RESET;
    invert_reg = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed rows run at the reset settings, with no idling.
    for (int i = 0; i < NUM_DIRECTED; i++) send_input(directed_rows[i], skipped);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_registers(phases[p].tab, phases[p].inv);
      idle_mode = phases[p].mode;
      useful = 0;
      tries = 0;
      // Inputs that change nothing do not count toward the phase size.
      while (useful < phases[p].items) begin
        pick_random_input(row);
        send_input(row, skipped);
        if (!skipped) useful++;
        tries++;
        // Now and then the sender holds back until the block has drained.
        if (tries % 97 == 0) wait_idle(0);
      end
    end

    idle_mode = IDLE_NONE;
    wait_idle(SETTLE_CYCLES);
    $display("Ran %0d inputs over %0d register settings in %0d cycles",
             inputs_sent, NUM_PHASES + 1, cycle_count);
    $display("Checked %0d results: %0d draws, %0d scrolls, %0d clears, %0d mismatches",
             cmds_checked, draws_seen, scrolls_seen, clears_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
